[hw/rtl/ccfp_pkg.sv]
package ccfp_pkg;

  // Row geometry.
  localparam int unsigned MAX_WIDTH   = 1024;
  localparam int unsigned MIN_WIDTH   = 2;
  localparam int unsigned WIDTH_RESET = 640;
  localparam int unsigned COL_W       = $clog2(MAX_WIDTH);
  localparam int unsigned WIDTH_W     = 11;

  // Labels and tables.
  localparam int unsigned LABEL_W    = 12;
  localparam int unsigned MAX_LABELS = 4095;
  localparam int unsigned NUM_LABELS = MAX_LABELS + 1;
  localparam int unsigned DEPTH_W    = 8;
  localparam int unsigned MASK_W     = 8;

  // Foreground counter.
  localparam int unsigned FG_W   = 21;
  localparam int unsigned FG_MAX = 2097151;

  // One merge job carries the four neighbor labels (west, north, northwest, northeast).
  localparam int unsigned SLOTS  = 4;
  localparam int unsigned SLOT_W = $clog2(SLOTS);

  typedef struct packed {
    logic [SLOTS-1:0][LABEL_W-1:0] lab;
    logic [LABEL_W-1:0]            target;
    logic [DEPTH_W-1:0]            depth;
    logic                          is_new;
  } ccfp_job_t;

endpackage

[hw/rtl/ccfp_ram.sv]
module ccfp_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // A read at the address being written returns the old contents.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/ccfp_merge.sv]
module ccfp_merge import ccfp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      job_valid_i,
  output logic      job_ready_o,
  input  ccfp_job_t job_i
);

  localparam logic [SLOT_W-1:0] SlotLast = SLOT_W'(SLOTS - 1);

  ccfp_job_t           job_q;
  logic                busy_q;
  logic [SLOT_W-1:0]   slot_q;
  logic                job_fire;

  logic [LABEL_W-1:0]  issue_lab;
  logic                issue_dep;

  logic                d_valid_q;
  logic [LABEL_W-1:0]  d_lab_q;
  logic [LABEL_W-1:0]  d_target_q;
  logic                d_force_q;
  logic                d_dep_q;
  logic [DEPTH_W-1:0]  d_depth_q;

  logic                wr_valid_q;
  logic [LABEL_W-1:0]  wr_addr_q;
  logic [LABEL_W-1:0]  wr_data_q;

  logic [LABEL_W-1:0]  eq_rdata;
  logic [LABEL_W-1:0]  eq_cur;
  logic                eq_we;
  logic [DEPTH_W-1:0]  dp_rdata;
  logic                dp_we;

  // A new job is taken while the last slot of the current one issues.
  assign job_ready_o = !busy_q || (slot_q == SlotLast);
  assign job_fire    = job_valid_i && job_ready_o;

  assign issue_lab = job_q.lab[slot_q];
  assign issue_dep = busy_q && (slot_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q     <= 1'b0;
      slot_q     <= '0;
      d_valid_q  <= 1'b0;
      d_dep_q    <= 1'b0;
      wr_valid_q <= 1'b0;
    end else begin
      if (job_fire) begin
        busy_q <= 1'b1;
        slot_q <= '0;
      end else if (busy_q) begin
        if (slot_q == SlotLast) begin
          busy_q <= 1'b0;
        end else begin
          slot_q <= slot_q + SLOT_W'(1);
        end
      end
      d_valid_q  <= busy_q;
      d_dep_q    <= issue_dep;
      wr_valid_q <= eq_we;
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_fire) begin
      job_q <= job_i;
    end
    d_lab_q    <= issue_lab;
    d_target_q <= job_q.target;
    d_force_q  <= job_q.is_new;
    d_depth_q  <= job_q.depth;
    wr_addr_q  <= d_lab_q;
    wr_data_q  <= d_target_q;
  end

  // The write that landed with this read is not seen by the RAM output, so
  // it is bypassed here.
  assign eq_cur = (wr_valid_q && (wr_addr_q == d_lab_q)) ? wr_data_q : eq_rdata;
  assign eq_we  = d_valid_q && (d_lab_q != '0) && (d_force_q || (d_target_q < eq_cur));
  assign dp_we  = d_valid_q && d_dep_q && (d_force_q || (d_depth_q < dp_rdata));

  ccfp_ram #(
    .Width(LABEL_W),
    .Depth(NUM_LABELS)
  ) u_eq_ram (
    .clk_i  (clk_i),
    .we_i   (eq_we),
    .waddr_i(d_lab_q),
    .wdata_i(d_target_q),
    .re_i   (busy_q),
    .raddr_i(issue_lab),
    .rdata_o(eq_rdata)
  );

  ccfp_ram #(
    .Width(DEPTH_W),
    .Depth(NUM_LABELS)
  ) u_depth_ram (
    .clk_i  (clk_i),
    .we_i   (dp_we),
    .waddr_i(d_target_q),
    .wdata_i(d_depth_q),
    .re_i   (issue_dep),
    .raddr_i(job_q.target),
    .rdata_o(dp_rdata)
  );

`ifndef SYNTH
  a_job_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_fire |=> busy_q && (slot_q == '0))
    else $error("merge job did not start at its first slot");

  a_data_follows_issue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    d_valid_q |-> $past(busy_q))
    else $error("merge data stage active without an issued read");
`endif

endmodule

[hw/rtl/connected_component_first_pass.sv]
// Channel   Direction  Signals                                    Beat
// cfg       in         cfg_valid_i/cfg_ready_o, cfg_image_width_i one row width write
// in        in         in_valid_i/in_ready_o, mask/depth/start    one pixel, raster order
// out       out        out_valid_o/out_ready_i, label/counts/flag one result per pixel
//
// A pixel beat reads the row store on its accepting edge, takes its label in the
// next cycle in the label stage and moves into the output register when that
// register is free and, for a labeled pixel, the equivalence unit takes its job.
// Background pixels and pixels that take no table work flow at one per cycle while
// the output register drains. Every labeled pixel hands one job to the equivalence
// unit, which works its four slots in turn (one equivalence table read-modify-write
// per neighbor on a single table port), taking a new job as the last slot issues.
// Reset clears control state only; the row store and both label tables hold no
// valid bits and need no clearing pass. Either side may stall at any time.
module connected_component_first_pass import ccfp_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,

  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [WIDTH_W-1:0] cfg_image_width_i,

  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [MASK_W-1:0]  mask_value_i,
  input  logic [DEPTH_W-1:0] depth_value_i,
  input  logic               frame_start_i,

  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [LABEL_W-1:0] pixel_label_o,
  output logic [LABEL_W-1:0] labels_issued_o,
  output logic [FG_W-1:0]    nonzero_count_o,
  output logic               label_overflow_o
);

  localparam logic [WIDTH_W-1:0] WidthMin   = WIDTH_W'(MIN_WIDTH);
  localparam logic [WIDTH_W-1:0] WidthMax   = WIDTH_W'(MAX_WIDTH);
  localparam logic [LABEL_W-1:0] LabelLimit = LABEL_W'(MAX_LABELS);
  localparam logic [FG_W-1:0]    FgLimit    = FG_W'(FG_MAX);

  // Smallest nonzero of two labels; zero means no label.
  function automatic logic [LABEL_W-1:0] pick_min(input logic [LABEL_W-1:0] best,
                                                  input logic [LABEL_W-1:0] cand);
    logic [LABEL_W-1:0] res;
    res = best;
    if (cand != '0 && (best == '0 || cand < best)) begin
      res = cand;
    end
    return res;
  endfunction

  // Configuration register.
  logic [WIDTH_W-1:0] width_q;
  logic [WIDTH_W-1:0] width_eff;

  // Position tracking at the input side.
  logic [COL_W-1:0]   col_q;
  logic               first_row_q;
  logic               in_fire;
  logic [COL_W-1:0]   col_s0;
  logic               first_s0;
  logic [WIDTH_W-1:0] col_inc;
  logic               last_s0;
  logic [COL_W-1:0]   rd_addr;

  // Label stage.
  logic               s1_valid_q;
  logic [COL_W-1:0]   s1_col_q;
  logic               s1_last_q;
  logic               s1_first_q;
  logic               s1_start_q;
  logic               s1_fg_q;
  logic [DEPTH_W-1:0] s1_depth_q;
  logic               fwd_q;
  logic [LABEL_W-1:0] fwd_label_q;
  logic               fwd_d;

  // Neighborhood registers.
  logic [LABEL_W-1:0] west_q;
  logic [LABEL_W-1:0] nw_q;
  logic [LABEL_W-1:0] ncarry_q;
  logic [LABEL_W-1:0] col0_q;

  // Frame counters.
  logic [LABEL_W-1:0] lcnt_q;
  logic [FG_W-1:0]    fg_q;
  logic               ovf_q;

  logic [LABEL_W-1:0] row_rdata;
  logic [LABEL_W-1:0] ne_raw;
  logic [LABEL_W-1:0] w_lab;
  logic [LABEL_W-1:0] n_lab;
  logic [LABEL_W-1:0] nw_lab;
  logic [LABEL_W-1:0] ne_lab;
  logic [LABEL_W-1:0] best;
  logic [LABEL_W-1:0] label;
  logic [LABEL_W-1:0] lcnt_d;
  logic [FG_W-1:0]    fg_d;
  logic               ovf_d;
  logic               job_need;
  logic               out_free;
  logic               s1_advance;

  ccfp_job_t          job;
  logic               job_valid;
  logic               job_ready;

  // Output register.
  logic               out_valid_q;
  logic [LABEL_W-1:0] out_label_q;
  logic [LABEL_W-1:0] out_issued_q;
  logic [FG_W-1:0]    out_fg_q;
  logic               out_ovf_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= WIDTH_W'(WIDTH_RESET);
    end else if (cfg_valid_i && cfg_ready_o) begin
      width_q <= cfg_image_width_i;
    end
  end

  // Out-of-range widths are clamped.
  always_comb begin
    width_eff = width_q;
    if (width_q < WidthMin) begin
      width_eff = WidthMin;
    end else if (width_q > WidthMax) begin
      width_eff = WidthMax;
    end
  end

  // Position only depends on width and frame start, so it is resolved at
  // accept time and the northeast read goes out at once.
  assign in_fire  = in_valid_i && in_ready_o;
  assign col_s0   = frame_start_i ? '0 : col_q;
  assign first_s0 = frame_start_i || first_row_q;
  assign col_inc  = {1'b0, col_s0} + WIDTH_W'(1);
  assign last_s0  = (col_inc >= width_eff);
  assign rd_addr  = col_inc[COL_W-1:0];

  // The pixel leaving the label stage writes the row store on the same edge;
  // if it hits the address being read (two-pixel rows), its label is bypassed.
  assign fwd_d = s1_advance && (s1_col_q == rd_addr);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= '0;
      first_row_q <= 1'b1;
      s1_valid_q  <= 1'b0;
    end else begin
      if (in_fire) begin
        col_q       <= last_s0 ? '0 : col_inc[COL_W-1:0];
        first_row_q <= last_s0 ? 1'b0 : first_s0;
        s1_valid_q  <= 1'b1;
      end else if (s1_advance) begin
        s1_valid_q  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_col_q    <= col_s0;
      s1_last_q   <= last_s0;
      s1_first_q  <= first_s0;
      s1_start_q  <= frame_start_i;
      s1_fg_q     <= (mask_value_i != '0);
      s1_depth_q  <= depth_value_i;
      fwd_q       <= fwd_d;
      fwd_label_q <= label;
    end
  end

  // Row store: labels of the previous row, indexed by column.
  ccfp_ram #(
    .Width(LABEL_W),
    .Depth(MAX_WIDTH)
  ) u_row_ram (
    .clk_i  (clk_i),
    .we_i   (s1_advance),
    .waddr_i(s1_col_q),
    .wdata_i(label),
    .re_i   (in_fire),
    .raddr_i(rd_addr),
    .rdata_o(row_rdata)
  );

  // Neighborhood. North comes from the northeast read of the previous pixel,
  // or from the column zero register at the start of a row.
  always_comb begin
    ne_raw = fwd_q ? fwd_label_q : row_rdata;
    w_lab  = (s1_col_q != '0) ? west_q : '0;
    nw_lab = (!s1_first_q && s1_col_q != '0) ? nw_q : '0;
    n_lab  = '0;
    if (!s1_first_q) begin
      n_lab = (s1_col_q != '0) ? ncarry_q : col0_q;
    end
    ne_lab = (s1_first_q || s1_last_q) ? '0 : ne_raw;
    best   = pick_min(pick_min(pick_min(pick_min('0, w_lab), n_lab), nw_lab), ne_lab);
  end

  // Label choice and frame counters.
  always_comb begin
    lcnt_d     = s1_start_q ? '0 : lcnt_q;
    fg_d       = s1_start_q ? '0 : fg_q;
    ovf_d      = s1_start_q ? 1'b0 : ovf_q;
    label      = '0;
    job        = '0;
    job_need   = 1'b0;
    if (s1_fg_q) begin
      if (fg_d < FgLimit) begin
        fg_d = fg_d + FG_W'(1);
      end
      if (best != '0 && best <= LabelLimit) begin
        label      = best;
        job_need   = 1'b1;
        job.lab[0] = w_lab;
        job.lab[1] = n_lab;
        job.lab[2] = nw_lab;
        job.lab[3] = ne_lab;
      end else if (lcnt_d < LabelLimit) begin
        lcnt_d     = lcnt_d + LABEL_W'(1);
        label      = lcnt_d;
        job_need   = 1'b1;
        job.is_new = 1'b1;
        job.lab[0] = lcnt_d;
      end else begin
        ovf_d = 1'b1;
      end
    end
    job.target = label;
    job.depth  = s1_depth_q;
  end

  assign out_free   = !out_valid_q || out_ready_i;
  assign job_valid  = s1_valid_q && out_free && job_need;
  assign s1_advance = s1_valid_q && out_free && (!job_need || job_ready);
  assign in_ready_o = !s1_valid_q || s1_advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      west_q      <= '0;
      nw_q        <= '0;
      col0_q      <= '0;
      lcnt_q      <= '0;
      fg_q        <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_advance) begin
        west_q <= s1_last_q ? '0 : label;
        nw_q   <= s1_last_q ? '0 : n_lab;
        if (s1_col_q == '0) begin
          col0_q <= label;
        end
        lcnt_q <= lcnt_d;
        fg_q   <= fg_d;
        ovf_q  <= ovf_d;
      end
      if (s1_advance) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_advance) begin
      ncarry_q     <= ne_raw;
      out_label_q  <= label;
      out_issued_q <= lcnt_d;
      out_fg_q     <= fg_d;
      out_ovf_q    <= ovf_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign pixel_label_o    = out_label_q;
  assign labels_issued_o  = out_issued_q;
  assign nonzero_count_o  = out_fg_q;
  assign label_overflow_o = out_ovf_q;

  // Equivalence and minimum depth tables.
  ccfp_merge u_merge (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .job_valid_i(job_valid),
    .job_ready_o(job_ready),
    .job_i      (job)
  );

`ifndef SYNTH
  a_ovf_means_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && label_overflow_o |-> labels_issued_o == LabelLimit)
    else $error("label overflow flagged with labels left");

  a_labels_within_fg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> nonzero_count_o >= FG_W'(labels_issued_o))
    else $error("more labels issued than foreground pixels");

  a_job_from_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_valid |-> s1_valid_q && out_free)
    else $error("merge job offered without a pixel in the label stage");
`endif

endmodule

[tb/testbench.sv]
`timescale 1ns / 100ps

// Testbench for the first pass of 8-connected component labeling.
//
// Pixels go in as beats on the input channel, and every beat produces exactly one
// result beat. The expected result of each accepted pixel is worked out right away
// by a predictor that keeps its own copy of the row store, the west and northwest
// labels, the column position, the counters and the row width register. The
// predictions wait in a queue, and a checker compares each result beat, field by
// field, against the oldest one.
//
// The equivalence table and the minimum depth table never reach the ports, so the
// predictor does not keep them. The pixel label, the issued count, the foreground
// count and the overflow flag are all decided without them.
//
// The row store holds garbage after reset. A row is only ever read after a full
// row has been written at the current width. Whenever a width write makes rows
// longer, the next pixel therefore carries frame_start. Shrinking the width in
// the middle of a frame stays legal, and is tested.
module testbench import ccfp_pkg::*; ();

  localparam int unsigned SETTLE_CYCLES = 8;      // equivalence unit may still be busy
  localparam int unsigned DRAIN_CYCLES  = 20;
  localparam int unsigned HOLD_CYCLES   = 300;    // long receiver hold-off
  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned PHASE_ITEMS   = 35;

  typedef struct {
    logic [LABEL_W-1:0] label;
    logic [LABEL_W-1:0] issued;
    logic [FG_W-1:0]    fg_count;
    logic               overflow;
  } pixel_result_t;

  // Clock and reset.
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  always #5 clk_i = ~clk_i;

  // Block inputs. All of them hold known values from time zero.
  logic               cfg_valid_i       = 1'b0;
  logic [WIDTH_W-1:0] cfg_image_width_i = '0;
  logic               in_valid_i        = 1'b0;
  logic [MASK_W-1:0]  mask_value_i      = '0;
  logic [DEPTH_W-1:0] depth_value_i     = '0;
  logic               frame_start_i     = 1'b0;
  logic               out_ready_i       = 1'b0;

  // Block outputs.
  logic               cfg_ready_o;
  logic               in_ready_o;
  logic               out_valid_o;
  logic [LABEL_W-1:0] pixel_label_o;
  logic [LABEL_W-1:0] labels_issued_o;
  logic [FG_W-1:0]    nonzero_count_o;
  logic               label_overflow_o;

  connected_component_first_pass i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_image_width_i(cfg_image_width_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .mask_value_i     (mask_value_i),
    .depth_value_i    (depth_value_i),
    .frame_start_i    (frame_start_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .pixel_label_o    (pixel_label_o),
    .labels_issued_o  (labels_issued_o),
    .nonzero_count_o  (nonzero_count_o),
    .label_overflow_o (label_overflow_o)
  );

  // Predictor state. These are the values that the block holds right after reset.
  logic [WIDTH_W-1:0] row_width_reg = WIDTH_W'(WIDTH_RESET);
  logic [LABEL_W-1:0] row_labels [MAX_WIDTH];
  logic [LABEL_W-1:0] west_lab      = '0;
  logic [LABEL_W-1:0] northwest_lab = '0;
  int unsigned        column        = 0;
  bit                 first_row     = 1'b1;
  logic [LABEL_W-1:0] issued_count  = '0;
  logic [FG_W-1:0]    fg_count      = '0;
  bit                 overflowed    = 1'b0;

  pixel_result_t predicted_pixels [$];
  pixel_result_t want;
  int unsigned   mismatches = 0;

  // Stimulus shaping, set by the tests.
  bit          force_frame_start = 1'b0;
  int unsigned max_gap           = 0;
  int unsigned burst_left        = 0;
  int unsigned ready_pct         = 100;
  bit          hold_request      = 1'b0;
  int unsigned cycle_count       = 0;

  // The register is 11 bits wide, but only 2 to MAX_WIDTH pixels per row are used.
  function automatic int unsigned clamp_width(logic [WIDTH_W-1:0] value);
    if (value < MIN_WIDTH) return MIN_WIDTH;
    if (value > MAX_WIDTH) return MAX_WIDTH;
    return 32'(value);
  endfunction

  // Labels one pixel and advances the raster position, in the same way as the block.
  function automatic pixel_result_t label_pixel(logic [MASK_W-1:0] mask, logic start);
    int unsigned        w;
    int unsigned        col;
    bit                 last;
    logic [LABEL_W-1:0] nbr [SLOTS];   // west, north, northwest, northeast
    logic [LABEL_W-1:0] best;
    logic [LABEL_W-1:0] lab;
    pixel_result_t      res;
    w = clamp_width(row_width_reg);
    if (start) begin
      issued_count  = '0;
      fg_count      = '0;
      overflowed    = 1'b0;
      column        = 0;
      first_row     = 1'b1;
      west_lab      = '0;
      northwest_lab = '0;
    end
    col  = column;
    // A shrunk width can leave the position past the new row end, and then this pixel
    // closes the row.
    last = (col + 1 >= w);
    if (col >= MAX_WIDTH) col = MAX_WIDTH - 1;

    nbr[0] = (col > 0) ? west_lab : '0;
    if (first_row) begin
      nbr[1] = '0;
      nbr[2] = '0;
      nbr[3] = '0;
    end else begin
      nbr[1] = row_labels[col];
      nbr[2] = (col > 0) ? northwest_lab : '0;
      nbr[3] = (!last && col + 1 < MAX_WIDTH) ? row_labels[col + 1] : '0;
    end

    lab = '0;
    if (mask != '0) begin
      if (fg_count < FG_MAX) fg_count++;
      best = '0;
      foreach (nbr[i]) begin
        if (nbr[i] != '0 && (best == '0 || nbr[i] < best)) best = nbr[i];
      end
      if (best != '0) begin
        lab = best;
      end else if (issued_count < MAX_LABELS) begin
        issued_count++;
        lab = issued_count;
      end else begin
        // Out of labels: the pixel stays unlabeled, but it still counts as foreground.
        overflowed = 1'b1;
      end
    end

    northwest_lab   = nbr[1];
    row_labels[col] = lab;
    west_lab        = lab;
    if (last) begin
      column        = 0;
      first_row     = 1'b0;
      west_lab      = '0;
      northwest_lab = '0;
    end else begin
      column = col + 1;
    end

    res.label    = lab;
    res.issued   = issued_count;
    res.fg_count = fg_count;
    res.overflow = overflowed;
    return res;
  endfunction

  // Offers one pixel beat and records its prediction once the beat is accepted.
  // Valid is left high after the beat. Here it only drops when a burst ends with a gap.
  task automatic push_pixel(logic [MASK_W-1:0] mask, logic [DEPTH_W-1:0] depth,
                            logic start);
    int unsigned gap;
    start             = start | force_frame_start;
    force_frame_start = 1'b0;
    in_valid_i    <= 1'b1;
    mask_value_i  <= mask;
    depth_value_i <= depth;
    frame_start_i <= start;
    do @(posedge clk_i); while (!in_ready_o);
    predicted_pixels.push_back(label_pixel(mask, start));
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = (max_gap > 0) ? $urandom_range(0, max_gap) : 0;
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  // Stops sending, waits for every predicted result, and then waits a few more
  // cycles so that the equivalence unit can finish the last job.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (predicted_pixels.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Writes the row width while the block is idle.
  task automatic write_width(logic [WIDTH_W-1:0] value);
    bit grows;
    grows = clamp_width(value) > clamp_width(row_width_reg);
    settle();
    cfg_valid_i       <= 1'b1;
    cfg_image_width_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i   <= 1'b0;
    row_width_reg  = value;
    // Longer rows would read row store entries that were never written.
    if (grows) force_frame_start = 1'b1;
  endtask

  // The reset width with no frame_start at all: mask and depth extremes first, then
  // enough sparse pixels to wrap into a second 640-pixel row.
  task automatic test_default_width();
    logic [MASK_W-1:0]  masks  [8] = '{8'h00, 8'h01, 8'hFF, 8'h80, 8'h7F, 8'h00, 8'h02, 8'hFE};
    logic [DEPTH_W-1:0] depths [8] = '{8'hFF, 8'h00, 8'hFF, 8'h00, 8'h55, 8'hAA, 8'h01, 8'hFE};
    max_gap   = 0;
    ready_pct = 100;
    foreach (masks[i]) push_pixel(masks[i], depths[i], 1'b0);
    max_gap   = 3;
    ready_pct = 70;
    for (int i = 8; i < 644; i++) begin
      push_pixel(($urandom_range(0, 99) < 25) ? 8'($urandom_range(1, 255)) : 8'h00,
                 8'($urandom_range(0, 255)), 1'b0);
    end
  endtask

  // Hand-drawn 4-wide shapes. They cover each neighbor on its own, the row edges,
  // and two labels that meet. Then comes a frame_start in the middle of a row.
  task automatic test_neighbors();
    bit shape [24] = '{1, 0, 1, 0,
                       0, 1, 0, 0,     // northwest and northeast: takes the smaller one
                       1, 0, 0, 1,     // northeast at column 0, new label at the row end
                       0, 0, 1, 1,     // northeast only, then west and north
                       1, 1, 1, 0,     // new label, which then meets an older one
                       1, 1, 0, 1};
    write_width(11'd4);
    max_gap   = 2;
    ready_pct = 50;
    foreach (shape[i]) begin
      push_pixel(shape[i] ? 8'($urandom_range(1, 255)) : 8'h00,
                 (i % 2 == 0) ? 8'h00 : 8'hFF, i == 0);
    end
    push_pixel(8'h10, 8'h20, 1'b0);
    push_pixel(8'hFF, 8'h00, 1'b1);
    push_pixel(8'h01, 8'hFF, 1'b0);
  endtask

  // Register extremes. Widths below 2 act as 2. Widths above MAX_WIDTH act as
  // MAX_WIDTH; only the start of such a long row is sent here.
  task automatic test_width_extremes();
    logic [WIDTH_W-1:0] narrow [3] = '{11'd0, 11'd1, 11'd2};
    bit                 twin   [8] = '{1, 1, 0, 1, 1, 0, 1, 1};
    max_gap   = 4;
    ready_pct = 80;
    foreach (narrow[n]) begin
      write_width(narrow[n]);
      foreach (twin[i]) push_pixel(twin[i] ? 8'hFF : 8'h00, 8'($urandom_range(0, 255)), i == 0);
    end
    write_width(11'h7FF);
    for (int i = 0; i < 16; i++) begin
      push_pixel(($urandom_range(0, 99) < 50) ? 8'($urandom_range(1, 255)) : 8'h00,
                 8'($urandom_range(0, 255)), i == 0);
    end
    write_width(11'd1024);
    for (int i = 0; i < 6; i++) push_pixel(8'hFF, 8'($urandom_range(0, 255)), 1'b0);
    write_width(11'd1025);
    for (int i = 0; i < 6; i++) push_pixel(8'h81, 8'($urandom_range(0, 255)), 1'b0);
  endtask

  // Shrinks the row in the middle of a frame, while the position lies past the new
  // row end.
  task automatic test_shrink_mid_frame();
    write_width(11'd16);
    max_gap   = 1;
    ready_pct = 90;
    for (int i = 0; i < 26; i++) begin
      push_pixel(($urandom_range(0, 1) == 1) ? 8'($urandom_range(1, 255)) : 8'h00,
                 8'($urandom_range(0, 255)), i == 0);
    end
    write_width(11'd4);
    for (int i = 0; i < 12; i++) begin
      push_pixel(($urandom_range(0, 1) == 1) ? 8'($urandom_range(1, 255)) : 8'h00,
                 8'($urandom_range(0, 255)), 1'b0);
    end
  endtask

  // One random phase: frames with random density at one width. Most frames are
  // started and sized cleanly. A few are cut short, run on without frame_start, or
  // get a stray frame_start.
  task automatic random_phase(int unsigned items, logic [WIDTH_W-1:0] width, bit long_hold);
    int unsigned sent;
    int unsigned frame_len;
    int unsigned density;
    bit          start;
    write_width(width);
    if (long_hold) hold_request = 1'b1;
    sent = 0;
    while (sent < items) begin
      frame_len = $urandom_range(1, 6) * clamp_width(width);
      if ($urandom_range(0, 9) == 0) frame_len = $urandom_range(1, frame_len);
      density = $urandom_range(5, 95);
      start   = ($urandom_range(0, 9) != 0);
      for (int i = 0; i < frame_len && sent < items; i++) begin
        push_pixel(($urandom_range(0, 99) < density) ? 8'($urandom_range(1, 255)) : 8'h00,
                   8'($urandom_range(0, 255)),
                   (i == 0) ? start : ($urandom_range(0, 199) == 0));
        sent++;
      end
    end
  endtask

  task automatic test_random();
    logic [WIDTH_W-1:0] width;
    for (int p = 0; p < 8; p++) begin
      case (p % 3)
        0: begin
          max_gap = 0;
        end
        1: begin
          max_gap = 3;
        end
        default: begin
          max_gap = 8;
        end
      endcase
      case (p % 4)
        0: begin
          ready_pct = 100;
        end
        1: begin
          ready_pct = 70;
        end
        2: begin
          ready_pct = 30;
        end
        default: begin
          ready_pct = 90;
        end
      endcase
      if (p == 3) begin
        width = WIDTH_W'($urandom_range(0, 1));
      end else if (p == 6) begin
        width = WIDTH_W'($urandom_range(21, 64));
      end else begin
        width = WIDTH_W'($urandom_range(2, 16));
      end
      random_phase(PHASE_ITEMS, width, p == 2);
    end
  endtask

  // The receiver stalls at a random rate. It sometimes holds off for a short burst,
  // and once, on request, for a long stretch that backs the block up to its input.
  initial begin : receiver
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_request = 1'b0;
      end else if (ready_pct < 100 && $urandom_range(0, 49) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end else begin
        out_ready_i <= ($urandom_range(0, 99) < ready_pct);
      end
    end
  end

  // Each result beat is compared with the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (predicted_pixels.size() == 0) begin
        $display("%0t: result beat with no pixel outstanding, label %0d",
                 $time, pixel_label_o);
        mismatches++;
      end else begin
        want = predicted_pixels.pop_front();
        if (pixel_label_o !== want.label) begin
          $display("%0t: pixel_label expected %0d, got %0d", $time, want.label, pixel_label_o);
          mismatches++;
        end
        if (labels_issued_o !== want.issued) begin
          $display("%0t: labels_issued expected %0d, got %0d",
                   $time, want.issued, labels_issued_o);
          mismatches++;
        end
        if (nonzero_count_o !== want.fg_count) begin
          $display("%0t: nonzero_count expected %0d, got %0d",
                   $time, want.fg_count, nonzero_count_o);
          mismatches++;
        end
        if (label_overflow_o !== want.overflow) begin
          $display("%0t: label_overflow expected %0d, got %0d",
                   $time, want.overflow, label_overflow_o);
          mismatches++;
        end
      end
    end
  end

  // A hung handshake ends the run here.
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("%0t: cycle limit reached with %0d results outstanding",
             $time, predicted_pixels.size());
    $display("** connected_component_first_pass: FAILED **");
    $finish;
  end

  initial begin : main
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_default_width();
    test_neighbors();
    test_width_extremes();
    test_shrink_mid_frame();
    test_random();
    settle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("** connected_component_first_pass: PASSED **");
    end else begin
      $display("** connected_component_first_pass: FAILED **");
    end
    $finish;
  end

endmodule
